// ===== design/bvm_pkg.sv =====
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared widths, constants, codes and types of the battery voltage monitor.
// ----------------------------------------------------------------------------
package bvm_pkg;

	// field widths
	localparam int CODE_W     = 16;
	localparam int UV_W       = 22;
	localparam int MV_W       = 15;
	localparam int RANGE_W    = 14;
	localparam int CAL_W      = 15;
	localparam int THR_W      = 10;
	localparam int PCT_W      = 7;
	localparam int TREND_W    = 2;
	localparam int CFG_DATA_W = 15;
	localparam int CFG_IDX_W  = 2;

	// scaling: uv * 133 * cal / (33 * 16384 * 1000), divisor = 4125 << 17
	localparam int PROD1_W = 30;
	localparam int PROD2_W = PROD1_W + CAL_W;
	localparam logic [6:0]  UV_PER_LSB    = 7'd125;
	localparam logic [7:0]  DIV_RATIO_NUM = 8'd133;
	localparam logic [29:0] SCALE_DIV     = 30'd540672000;
	localparam logic [MV_W-1:0] SAMPLE_MAX = '1;

	// divide by 4125 as a reciprocal multiply, exact for any 28-bit operand
	localparam int SCALE_SHIFT  = 17;
	localparam int SCALED_W     = PROD2_W - SCALE_SHIFT;
	localparam int RECIP_W      = 29;
	localparam logic [RECIP_W-1:0] SCALE_RECIP = 29'd533096547;  // ceil(2^41 / 4125)
	localparam int RECIP_SHIFT  = 41;
	localparam int RECIP_PROD_W = SCALED_W + RECIP_W;
	localparam int SAMPLE_Q_W   = RECIP_PROD_W - RECIP_SHIFT;

	// shared divider: average and percent
	localparam int DIVD_W = MV_W + PCT_W;
	localparam int DIVS_W = RANGE_W;
	localparam int QUOT_W = 16;
	localparam int QCNT_W = $clog2(QUOT_W);
	localparam int DSR_W  = DIVS_W + QUOT_W;

	// percent
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam int PCT_NUM_W = MV_W + PCT_W;

	// moving average window
	localparam int AVG_DEPTH = 5;
	localparam int AVG_IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int AVG_CNT_W = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W     = MV_W + ((AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 0);

	// history ring
	localparam int HIST_DEPTH = 12;
	localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
	localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

	typedef enum logic [TREND_W-1:0] {
		TREND_STABLE      = 2'd0,
		TREND_CHARGING    = 2'd1,
		TREND_DISCHARGING = 2'd2
	} trend_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_SMP_MUL,
		ST_SMP_WR,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_PCT_GO,
		ST_PCT_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic              ovf;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== design/bvm_ram.sv =====
// ----------------------------------------------------------------------------
// bvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bvm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/bvm_div.sv =====
// ----------------------------------------------------------------------------
// bvm_div
// Restoring divider, one quotient bit per cycle, QUOT_W bits per divide.
// Flags overflow when the quotient does not fit in QUOT_W bits.
// ----------------------------------------------------------------------------
module bvm_div import bvm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic              ovf_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [DIVD_W-1:0] rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [QUOT_W-1:0] quot_q;

	logic [DSR_W-1:0]  rem_ext;
	logic              ge;
	logic [DSR_W-1:0]  rem_sub;

	// trial subtract of the shifted divisor
	always_comb begin
		rem_ext = DSR_W'(rem_q);
		ge      = (rem_ext >= dsr_q);
		rem_sub = rem_ext - dsr_q;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && (cnt_q == '0)) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			dsr_q  <= DSR_W'({req.divisor, {(QUOT_W-1){1'b0}}});
			ovf_q  <= (DSR_W'(req.dividend) >= {req.divisor, {QUOT_W{1'b0}}});
			quot_q <= '0;
			cnt_q  <= QCNT_W'(QUOT_W - 1);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_sub[DIVD_W-1:0];
			end
			quot_q <= {quot_q[QUOT_W-2:0], ge};
			dsr_q  <= dsr_q >> 1;
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quot = quot_q;

endmodule

// ===== design/battery_voltage_monitor.sv =====
// ----------------------------------------------------------------------------
// battery_voltage_monitor
// Scales ADC codes to battery millivolts, keeps a moving average and a ring
// of past averages, and reports charge percent and voltage trend.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  in       input      in_valid / in_stall       adc_code
//  out      output     out_valid / out_stall     divider_uv, battery_mv,
//                                                charge_percent, trend
//  cfg      input      cfg_wr_en                 cfg_addr, cfg_wdata
//
//  One word at a time: a new word is accepted only in the idle state. Sample
//  scaling is three multiplies and a window write; the rest is set by the
//  shared divider, each divide a start, 16 quotient bits and a done, with two
//  divides per word (average, percent); the percent divide is skipped when the
//  range is empty or the average is at or below the range minimum.
//  Reset clears the fill counts and running sum; the window and history RAMs
//  need no clearing. A stalled result waits in the output register while the
//  next word is accepted; the block holds in its last state until it frees.
//
module battery_voltage_monitor import bvm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// input words
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CODE_W-1:0]     adc_code,
	// result words
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [UV_W-1:0]       divider_uv,
	output logic [MV_W-1:0]       battery_mv,
	output logic [PCT_W-1:0]      charge_percent,
	output logic [TREND_W-1:0]    trend
);

	state_t state_q, state_d;

	// configuration registers
	logic [RANGE_W-1:0] range_min_q;
	logic [RANGE_W-1:0] range_max_q;
	logic [CAL_W-1:0]   cal_q;
	logic [THR_W-1:0]   thr_q;

	// per-word datapath
	logic [UV_W-1:0]    uv_q;
	logic [PROD1_W-1:0] prod1_q;
	logic [PROD2_W-1:0] prod2_q;
	logic [MV_W-1:0]    sample_q;
	logic [MV_W-1:0]    avg_q;
	logic [MV_W-1:0]    oldest_q;
	logic [PCT_W-1:0]   pct_q;

	// window and history bookkeeping
	logic [SUM_W-1:0]      sum_q;
	logic [AVG_IDX_W-1:0]  avg_slot_q;
	logic [AVG_CNT_W-1:0]  avg_fill_q;
	logic [HIST_IDX_W-1:0] hist_slot_q;
	logic [HIST_CNT_W-1:0] hist_fill_q;

	// output register
	logic               out_valid_q;
	logic [UV_W-1:0]    out_uv_q;
	logic [MV_W-1:0]    out_mv_q;
	logic [PCT_W-1:0]   out_pct_q;
	trend_t             out_trend_q;

	// internal connections
	div_req_t              div_req;
	div_rsp_t              div_rsp;
	logic                  win_we;
	logic [MV_W-1:0]       win_rdata;
	logic                  hist_we;
	logic [HIST_IDX_W-1:0] hist_raddr;
	logic [MV_W-1:0]       hist_rdata;

	logic                  in_fire;
	logic                  out_free;
	logic [RECIP_PROD_W-1:0] recip_prod;
	logic [SAMPLE_Q_W-1:0] sample_quot;
	logic [MV_W-1:0]       sample_mv;
	logic [MV_W-1:0]       win_old;
	logic [MV_W-1:0]       avg_new;
	logic                  pct_skip;
	logic [MV_W-1:0]       avg_diff;
	logic [PCT_NUM_W-1:0]  pct_num;
	logic [PCT_W-1:0]      pct_new;
	logic                  hist_full;
	trend_t                trend_new;

	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// ---------------------------------------------------------------------
	// Combinational datapath
	// ---------------------------------------------------------------------

	// sample scaling: drop the power-of-two part, multiply by 1/4125, saturate
	always_comb begin
		recip_prod  = RECIP_PROD_W'(prod2_q[PROD2_W-1:SCALE_SHIFT])
			* RECIP_PROD_W'(SCALE_RECIP);
		sample_quot = recip_prod[RECIP_PROD_W-1:RECIP_SHIFT];
		sample_mv   = sample_quot[MV_W] ? SAMPLE_MAX : sample_quot[MV_W-1:0];
	end

	// divider results: average, clamped percent
	always_comb begin
		avg_new   = div_rsp.quot[MV_W-1:0];
		pct_new   = (div_rsp.ovf || (div_rsp.quot > QUOT_W'(PCT_FULL))) ? PCT_FULL
			: div_rsp.quot[PCT_W-1:0];
	end

	// old window entry counts only once the window has wrapped
	assign win_old = (avg_fill_q == AVG_CNT_W'(AVG_DEPTH)) ? win_rdata : '0;

	// oldest history entry sits in the slot after the one being written
	assign hist_raddr = (hist_slot_q == HIST_IDX_W'(HIST_DEPTH - 1)) ? '0
		: hist_slot_q + 1'b1;

	// percent operands
	always_comb begin
		pct_skip = (range_max_q <= range_min_q) || (avg_q <= MV_W'(range_min_q));
		avg_diff = avg_q - MV_W'(range_min_q);
		pct_num  = PCT_NUM_W'(avg_diff) * PCT_NUM_W'(PCT_FULL);
	end

	// trend against the oldest average
	always_comb begin
		hist_full = (hist_fill_q == HIST_CNT_W'(HIST_DEPTH));
		trend_new = TREND_STABLE;
		if (hist_full) begin
			if ((avg_q > oldest_q) && ((avg_q - oldest_q) > MV_W'(thr_q))) begin
				trend_new = TREND_CHARGING;
			end else if ((oldest_q > avg_q) && ((oldest_q - avg_q) > MV_W'(thr_q))) begin
				trend_new = TREND_DISCHARGING;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sequencer: next state
	// ---------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1:    state_d = ST_MUL2;
			ST_MUL2:    state_d = ST_SMP_MUL;
			ST_SMP_MUL: state_d = ST_SMP_WR;
			ST_SMP_WR:  state_d = ST_AVG_GO;
			ST_AVG_GO:  state_d = ST_AVG_WAIT;
			ST_AVG_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_PCT_GO;
				end
			end
			ST_PCT_GO: state_d = pct_skip ? ST_OUT : ST_PCT_WAIT;
			ST_PCT_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------
	// Sequencer: outputs
	// ---------------------------------------------------------------------
	always_comb begin
		in_stall         = 1'b1;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		win_we           = 1'b0;
		hist_we          = 1'b0;
		case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_SMP_WR: win_we   = 1'b1;
			ST_AVG_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIVD_W'(sum_q);
				div_req.divisor  = DIVS_W'(avg_fill_q);
			end
			ST_AVG_WAIT: hist_we = div_rsp.done;
			ST_PCT_GO: begin
				div_req.start    = !pct_skip;
				div_req.dividend = DIVD_W'(pct_num);
				div_req.divisor  = DIVS_W'(range_max_q - range_min_q);
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------------
	// State and bookkeeping registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			avg_slot_q  <= '0;
			avg_fill_q  <= '0;
			hist_slot_q <= '0;
			hist_fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// window update once the sample is known
			if (win_we) begin
				sum_q      <= sum_q + SUM_W'(sample_q) - SUM_W'(win_old);
				avg_slot_q <= (avg_slot_q == AVG_IDX_W'(AVG_DEPTH - 1)) ? '0
					: avg_slot_q + 1'b1;
				if (avg_fill_q != AVG_CNT_W'(AVG_DEPTH)) begin
					avg_fill_q <= avg_fill_q + 1'b1;
				end
			end
			// history ring update once the average is known
			if (hist_we) begin
				hist_slot_q <= hist_raddr;
				if (hist_fill_q != HIST_CNT_W'(HIST_DEPTH)) begin
					hist_fill_q <= hist_fill_q + 1'b1;
				end
			end
			// result word handshake
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= 14'd11800;
			range_max_q <= 14'd12600;
			cal_q       <= 15'd16384;
			thr_q       <= 10'd50;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_RANGE_MIN: range_min_q <= cfg_wdata[RANGE_W-1:0];
				REG_RANGE_MAX: range_max_q <= cfg_wdata[RANGE_W-1:0];
				REG_CAL:       cal_q       <= cfg_wdata[CAL_W-1:0];
				REG_THRESHOLD: thr_q       <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Payload registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			uv_q <= adc_code[CODE_W-1] ? '0
				: UV_W'(adc_code[CODE_W-2:0]) * UV_W'(UV_PER_LSB);
		end
		if (state_q == ST_MUL1) begin
			prod1_q <= PROD1_W'(uv_q) * PROD1_W'(DIV_RATIO_NUM);
		end
		if (state_q == ST_MUL2) begin
			prod2_q <= PROD2_W'(prod1_q) * PROD2_W'(cal_q);
		end
		if (state_q == ST_SMP_MUL) begin
			sample_q <= sample_mv;
		end
		if (hist_we) begin
			avg_q    <= avg_new;
			oldest_q <= hist_rdata;
		end
		if (state_q == ST_PCT_GO) begin
			pct_q <= '0;
		end else if ((state_q == ST_PCT_WAIT) && div_rsp.done) begin
			pct_q <= pct_new;
		end
		if ((state_q == ST_OUT) && out_free) begin
			out_uv_q    <= uv_q;
			out_mv_q    <= avg_q;
			out_pct_q   <= pct_q;
			out_trend_q <= trend_new;
		end
	end

	// ---------------------------------------------------------------------
	// Instances
	// ---------------------------------------------------------------------
	bvm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bvm_ram #(
		.WIDTH (MV_W),
		.DEPTH (AVG_DEPTH)
	) u_window_ram (
		.clk   (clk),
		.we    (win_we),
		.waddr (avg_slot_q),
		.wdata (sample_q),
		.raddr (avg_slot_q),
		.rdata (win_rdata)
	);

	bvm_ram #(
		.WIDTH (MV_W),
		.DEPTH (HIST_DEPTH)
	) u_history_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_slot_q),
		.wdata (avg_new),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	// outputs
	assign out_valid      = out_valid_q;
	assign divider_uv     = out_uv_q;
	assign battery_mv     = out_mv_q;
	assign charge_percent = out_pct_q;
	assign trend          = out_trend_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------

	// divider is never restarted while a divide is running
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// divider completions land only in a wait state
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_AVG_WAIT || state_q == ST_PCT_WAIT))
		else $error("divider result with no consumer");

	// an accepted word starts the scaling sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_MUL1))
		else $error("accepted word not started");

	// fill counts never pass the storage depth
	assert property (@(posedge clk) disable iff (!arst_n)
		(avg_fill_q <= AVG_CNT_W'(AVG_DEPTH)) && (hist_fill_q <= HIST_CNT_W'(HIST_DEPTH)))
		else $error("fill count out of range");

endmodule
